// ===== src/prac_pkg.sv =====
// shared constants, types and helper functions for the planar rotation accumulator
// no dependencies; used by prac_ctrl, prac_dp and the top level
`timescale 1ns / 1ps
`default_nettype none
package prac_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CNT_W = 5;
  localparam int XW = 36;

  localparam logic signed [18:0] PI_Q15      = 19'sd102944;
  localparam logic signed [18:0] HALF_PI_Q15 = 19'sd51472;
  localparam logic signed [18:0] TWO_PI_Q15  = 19'sd205887;
  localparam logic signed [XW-1:0] PI_Q30    = 36'sd3373259426;
  localparam logic signed [XW-1:0] GAIN_Q30  = 36'sd652032874;
  localparam logic [29:0] GAIN_U30           = 30'd652032874;
  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;

  typedef enum logic [1:0] {
    ACT_SET = 2'd0,
    ACT_VEC = 2'd1,
    ACT_ADD = 2'd2,
    ACT_SUB = 2'd3
  } act_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic             capture;
    logic             rot_load;
    logic             rot_from_vec;
    logic             vec_load;
    logic             vec_from_cur;
    logic             iter;
    logic             rot_to_cur;
    logic             rot_to_opd;
    logic             neg_s;
    logic             vec_to_cur;
    logic             vec_to_hold;
    logic             mag_mul;
    logic             fallback;
    logic             mul_step;
    logic             mul_end;
    logic             out_load;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  // arctangent of 2^-i in units of 2^-30 radian
  function automatic logic signed [XW-1:0] atan_lut(input logic [CNT_W-1:0] i);
    logic signed [XW-1:0] r;
    case (i)
      5'd0:  r = 36'sd843314857;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043837;
      5'd3:  r = 36'sd133525159;
      5'd4:  r = 36'sd67021687;
      5'd5:  r = 36'sd33543516;
      5'd6:  r = 36'sd16775851;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194283;
      5'd9:  r = 36'sd2097149;
      5'd10: r = 36'sd1048576;
      5'd11: r = 36'sd524288;
      5'd12: r = 36'sd262144;
      5'd13: r = 36'sd131072;
      5'd14: r = 36'sd65536;
      5'd15: r = 36'sd32768;
      5'd16: r = 36'sd16384;
      5'd17: r = 36'sd8192;
      5'd18: r = 36'sd4096;
      5'd19: r = 36'sd2048;
      5'd20: r = 36'sd1024;
      5'd21: r = 36'sd512;
      5'd22: r = 36'sd256;
      5'd23: r = 36'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // shift right with rounding half away from zero
  function automatic logic signed [XW-1:0] round_q(input logic signed [XW-1:0] v,
                                                   input int unsigned s);
    logic signed [XW-1:0] h;
    h = 36'sd1 <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -(((-v) + h) >>> s);
  endfunction

  // saturate to plus or minus one in Q1.14
  function automatic logic signed [15:0] clamp_one(input logic signed [XW-1:0] v);
    if (v > 36'sd16384) return ONE_Q14;
    if (v < -36'sd16384) return -ONE_Q14;
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/prac_dp.sv =====
// datapath: shared cordic unit, complex multiplier, magnitude check and stored rotation
// depends on prac_pkg; driven by prac_ctrl commands
`timescale 1ns / 1ps
`default_nettype none
module prac_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire prac_pkg::cmd_t      cmd,
  output logic                     mag_small,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_data,
  input  wire logic signed [17:0]  angle_in,
  input  wire logic signed [15:0]  vec_x,
  input  wire logic signed [15:0]  vec_y,
  output logic signed [17:0]       angle_out,
  output logic signed [15:0]       cos_out,
  output logic signed [15:0]       sin_out
);

  localparam int XW = prac_pkg::XW;

  logic [15:0]             magnitude_floor;
  logic signed [17:0]      in_ang;
  logic signed [15:0]      vx, vy;
  logic signed [XW-1:0]    x, y, z, off;
  logic                    zero_vec;
  logic                    neg_r;
  logic signed [17:0]      rot_ang;
  logic signed [17:0]      hold_ang;
  logic [31:0]             hold_mag;
  logic [61:0]             mag_prod;
  logic signed [15:0]      oc, os;
  logic signed [33:0]      acc_c, acc_s;
  logic signed [17:0]      cur_angle;
  logic signed [15:0]      cur_cos, cur_sin;

  // input angle wrapped once by two pi
  logic signed [18:0] a19, a_wrap;
  always_comb begin
    a19 = {angle_in[17], angle_in};
    if (a19 > prac_pkg::PI_Q15) a_wrap = a19 - prac_pkg::TWO_PI_Q15;
    else if (a19 < -prac_pkg::PI_Q15) a_wrap = a19 + prac_pkg::TWO_PI_Q15;
    else a_wrap = a19;
  end

  // rotation start: fold into plus or minus half pi
  logic signed [17:0] r_src;
  logic signed [18:0] r19, r_fold;
  logic               r_neg;
  always_comb begin
    r_src = cmd.rot_from_vec ? hold_ang : in_ang;
    r19 = {r_src[17], r_src};
    r_neg = 1'b0;
    r_fold = r19;
    if (r19 > prac_pkg::HALF_PI_Q15) begin
      r_fold = r19 - prac_pkg::PI_Q15;
      r_neg = 1'b1;
    end else if (r19 < -prac_pkg::HALF_PI_Q15) begin
      r_fold = r19 + prac_pkg::PI_Q15;
      r_neg = 1'b1;
    end
  end

  // vectoring start operands
  logic signed [15:0]   sx, sy;
  logic signed [XW-1:0] vx36, vy36;
  always_comb begin
    sx = cmd.vec_from_cur ? cur_cos : vx;
    sy = cmd.vec_from_cur ? cur_sin : vy;
    vx36 = {{(XW-16){sx[15]}}, sx} <<< 14;
    vy36 = {{(XW-16){sy[15]}}, sy} <<< 14;
  end

  // one cordic micro-rotation
  logic signed [XW-1:0] xs, ys, at;
  always_comb begin
    xs = x >>> cmd.idx;
    ys = y >>> cmd.idx;
    at = prac_pkg::atan_lut(cmd.idx);
  end

  logic rot_mode;

  // rotation end results
  logic signed [XW-1:0] rx, ry;
  logic signed [15:0]   rc, rs;
  always_comb begin
    rx = prac_pkg::round_q(x, 16);
    ry = prac_pkg::round_q(y, 16);
    if (neg_r) begin
      rx = -rx;
      ry = -ry;
    end
    rc = prac_pkg::clamp_one(rx);
    rs = prac_pkg::clamp_one(ry);
  end

  // vectoring end angle
  logic signed [XW-1:0] vz;
  logic signed [17:0]   vang;
  always_comb begin
    vz = prac_pkg::round_q(z + off, 15);
    if (zero_vec) vang = '0;
    else if (vz > 36'sd102944) vang = 18'sd102944;
    else if (vz < -36'sd102944) vang = -18'sd102944;
    else vang = vz[17:0];
  end

  // magnitude in input units against the floor
  logic [61:0] mag_rnd;
  always_comb begin
    mag_rnd = (mag_prod + (62'd1 << 43)) >> 44;
    mag_small = mag_rnd[17:0] <= {2'b00, magnitude_floor};
  end

  // shared multiplier for the complex product
  logic signed [15:0] ma, mb;
  logic signed [31:0] prod;
  always_comb begin
    case (cmd.idx[1:0])
      2'd0:    begin ma = cur_cos; mb = oc; end
      2'd1:    begin ma = cur_sin; mb = os; end
      2'd2:    begin ma = cur_cos; mb = os; end
      default: begin ma = cur_sin; mb = oc; end
    endcase
    prod = ma * mb;
  end

  logic signed [XW-1:0] nc, ns;
  always_comb begin
    nc = prac_pkg::round_q({{(XW-34){acc_c[33]}}, acc_c}, 14);
    ns = prac_pkg::round_q({{(XW-34){acc_s[33]}}, acc_s}, 14);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) magnitude_floor <= '0;
    else if (cfg_we) magnitude_floor <= cfg_data;
  end

  // cordic unit and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_ang <= a_wrap[17:0];
      vx <= vec_x;
      vy <= vec_y;
    end
    if (cmd.rot_load) begin
      rot_mode <= 1'b1;
      neg_r <= r_neg;
      rot_ang <= r_src;
      x <= prac_pkg::GAIN_Q30;
      y <= '0;
      z <= {{(XW-19){r_fold[18]}}, r_fold} <<< 15;
    end else if (cmd.vec_load) begin
      rot_mode <= 1'b0;
      zero_vec <= (sx == 16'sd0) && (sy == 16'sd0);
      z <= '0;
      if (sx < 0) begin
        off <= (sy >= 0) ? prac_pkg::PI_Q30 : -prac_pkg::PI_Q30;
        x <= -vx36;
        y <= -vy36;
      end else begin
        off <= '0;
        x <= vx36;
        y <= vy36;
      end
    end else if (cmd.iter) begin
      if (rot_mode ? (z >= 0) : (y > 0)) begin
        x <= rot_mode ? x - ys : x + ys;
        y <= rot_mode ? y + xs : y - xs;
        z <= rot_mode ? z - at : z + at;
      end else begin
        x <= rot_mode ? x + ys : x - ys;
        y <= rot_mode ? y - xs : y + xs;
        z <= rot_mode ? z + at : z - at;
      end
    end
    if (cmd.rot_to_opd) begin
      oc <= rc;
      os <= cmd.neg_s ? -rs : rs;
    end
    if (cmd.vec_to_hold) begin
      hold_ang <= vang;
      hold_mag <= x[31:0];
    end
    if (cmd.mag_mul) mag_prod <= hold_mag * {2'b00, prac_pkg::GAIN_U30};
    if (cmd.mul_step) begin
      case (cmd.idx[1:0])
        2'd0:    acc_c <= {{2{prod[31]}}, prod};
        2'd1:    acc_c <= acc_c - {{2{prod[31]}}, prod};
        2'd2:    acc_s <= {{2{prod[31]}}, prod};
        default: acc_s <= acc_s + {{2{prod[31]}}, prod};
      endcase
    end
    if (cmd.out_load) begin
      angle_out <= cur_angle;
      cos_out <= cur_cos;
      sin_out <= cur_sin;
    end
  end

  // stored rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_angle <= '0;
      cur_cos <= prac_pkg::ONE_Q14;
      cur_sin <= '0;
    end else if (cmd.fallback) begin
      cur_angle <= '0;
      cur_cos <= prac_pkg::ONE_Q14;
      cur_sin <= '0;
    end else if (cmd.rot_to_cur) begin
      cur_angle <= rot_ang;
      cur_cos <= rc;
      cur_sin <= rs;
    end else if (cmd.mul_end) begin
      cur_cos <= prac_pkg::clamp_one(nc);
      cur_sin <= prac_pkg::clamp_one(ns);
    end else if (cmd.vec_to_cur) begin
      cur_angle <= vang;
    end
  end

  // stored rotation stays in range
  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    cur_cos <= 16'sd16384 && cur_cos >= -16'sd16384)
    else $error("cur_cos out of range");
  a_sin_range: assert property (@(posedge clk) disable iff (rst)
    cur_sin <= 16'sd16384 && cur_sin >= -16'sd16384)
    else $error("cur_sin out of range");
  a_ang_range: assert property (@(posedge clk) disable iff (rst)
    cur_angle <= 18'sd102944 && cur_angle >= -18'sd102944)
    else $error("cur_angle out of range");

endmodule
`default_nettype wire

// ===== src/prac_ctrl.sv =====
// controller: sequences the cordic passes, the complex product and the handshakes
// depends on prac_pkg; drives prac_dp
`timescale 1ns / 1ps
`default_nettype none
module prac_ctrl #(
  parameter int CORDIC_STEPS = prac_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     action,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire logic           mag_small,
  output prac_pkg::cmd_t      cmd
);

  localparam int CNT_W = prac_pkg::CNT_W;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(3);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_ROT_LOAD = 11'b00000000010,
    S_VEC_LOAD = 11'b00000000100,
    S_ITER     = 11'b00000001000,
    S_ROT_END  = 11'b00000010000,
    S_VEC_END  = 11'b00000100000,
    S_MAG      = 11'b00001000000,
    S_MAG_CHK  = 11'b00010000000,
    S_MUL      = 11'b00100000000,
    S_MUL_END  = 11'b01000000000,
    S_OUT      = 11'b10000000000
  } state_t;

  state_t             state, state_next;
  prac_pkg::act_t     act;
  logic               rot_mode, rot_mode_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               addsub;

  assign addsub = (act == prac_pkg::ACT_ADD) || (act == prac_pkg::ACT_SUB);
  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    rot_mode_next = rot_mode;
    cnt_next = cnt;
    cmd = '0;
    cmd.idx = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = (prac_pkg::act_t'(action) == prac_pkg::ACT_VEC) ? S_VEC_LOAD
                                                                        : S_ROT_LOAD;
        end
      end
      S_ROT_LOAD: begin
        cmd.rot_load = 1'b1;
        cmd.rot_from_vec = (act == prac_pkg::ACT_VEC);
        rot_mode_next = 1'b1;
        cnt_next = '0;
        state_next = S_ITER;
      end
      S_VEC_LOAD: begin
        cmd.vec_load = 1'b1;
        cmd.vec_from_cur = addsub;
        rot_mode_next = 1'b0;
        cnt_next = '0;
        state_next = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) state_next = rot_mode ? S_ROT_END : S_VEC_END;
      end
      S_ROT_END: begin
        cnt_next = '0;
        if (addsub) begin
          cmd.rot_to_opd = 1'b1;
          cmd.neg_s = (act == prac_pkg::ACT_SUB);
          state_next = S_MUL;
        end else begin
          cmd.rot_to_cur = 1'b1;
          state_next = S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == MUL_LAST) state_next = S_MUL_END;
      end
      S_MUL_END: begin
        cmd.mul_end = 1'b1;
        state_next = S_VEC_LOAD;
      end
      S_VEC_END: begin
        if (act == prac_pkg::ACT_VEC) begin
          cmd.vec_to_hold = 1'b1;
          state_next = S_MAG;
        end else begin
          cmd.vec_to_cur = 1'b1;
          state_next = S_OUT;
        end
      end
      S_MAG: begin
        cmd.mag_mul = 1'b1;
        state_next = S_MAG_CHK;
      end
      S_MAG_CHK: begin
        if (mag_small) begin
          cmd.fallback = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_ROT_LOAD;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rot_mode <= 1'b0;
      cnt <= '0;
      act <= prac_pkg::ACT_SET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rot_mode <= rot_mode_next;
      cnt <= cnt_next;
      if (cmd.capture) act <= prac_pkg::act_t'(action);
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // iteration count stays within the configured pass length
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ITER |-> cnt <= LAST)
    else $error("cordic count overrun");
  // the result register is only reloaded once the previous item is gone
  a_out_safe: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten");
  // a waiting result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");

endmodule
`default_nettype wire

// ===== src/planar_rotation_accumulator.sv =====
// Keeps one planar rotation as angle (Q3.15 radians) with cosine and sine (Q1.14).
// Actions: set angle, set from vector (atan2 with magnitude floor fallback), add and
// subtract angle. One shared CORDIC unit does one micro-rotation per cycle. Set
// angle makes a rotation pass, set from vector a vectoring pass and, unless the
// floor fallback is taken, a rotation pass, and add and subtract a rotation pass,
// the complex product and a vectoring pass. One item is in work at a time; a new
// item is taken once the previous result has moved to the output register.
// depends on prac_pkg, prac_ctrl, prac_dp
`timescale 1ns / 1ps
`default_nettype none
module planar_rotation_accumulator #(
  parameter int CORDIC_STEPS = prac_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         action,
  input  wire logic signed [17:0] angle_in,
  input  wire logic signed [15:0] vec_x,
  input  wire logic signed [15:0] vec_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [17:0]      angle_out,
  output logic signed [15:0]      cos_out,
  output logic signed [15:0]      sin_out
);

  prac_pkg::cmd_t cmd;
  logic           mag_small;

  // sequencer
  prac_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .out_valid(out_valid), .out_ready(out_ready),
    .mag_small(mag_small), .cmd(cmd)
  );

  // arithmetic and state
  prac_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .mag_small(mag_small),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .angle_in(angle_in), .vec_x(vec_x), .vec_y(vec_y),
    .angle_out(angle_out), .cos_out(cos_out), .sin_out(sin_out)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_planar_rotation_accumulator.sv =====
// testbench for planar_rotation_accumulator: directed table then random items, each
// result checked field by field against an in-bench fixed-point rotation predictor or
// a typed row's want; depends on prac_pkg and the planar_rotation_accumulator RTL
`timescale 1ns / 1ps
module tb_planar_rotation_accumulator;

  localparam int  N_STEPS    = 16;
  localparam int  RAND_ITEMS = 930;
  localparam int  DRAIN_CYC  = 60;
  localparam longint CYC_LIMIT = 600000;

  // arctangent of 2^-i, units of 2^-30 radian
  localparam longint ATAN_Q30 [0:15] = '{
    843314857, 497837829, 263043837, 133525159,
    67021687,  33543516,  16775851,  8388437,
    4194283,   2097149,   1048576,   524288,
    262144,    131072,    65536,     32768
  };

  typedef struct {
    logic signed [17:0] angle;
    logic signed [15:0] cosv;
    logic signed [15:0] sinv;
  } rot_t;

  typedef struct {
    prac_pkg::act_t     act;
    logic signed [17:0] ang;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    int                 floor_val;
    bit                 typed;
    rot_t               want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] action = '0;
  logic signed [17:0] angle_in = '0;
  logic signed [15:0] vec_x = '0;
  logic signed [15:0] vec_y = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [17:0] angle_out;
  logic signed [15:0] cos_out;
  logic signed [15:0] sin_out;

  planar_rotation_accumulator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .angle_in(angle_in), .vec_x(vec_x), .vec_y(vec_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .angle_out(angle_out), .cos_out(cos_out), .sin_out(sin_out)
  );

  // 12 ns clock
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // predictor state
  int   pr_angle, pr_cos, pr_sin;
  int   pr_floor;
  rot_t pending_rot[$];
  row_t dir_tab[$];
  int   err_cnt = 0;
  int   send_idle = 0, recv_idle = 0;
  longint cyc = 0;

  function automatic longint round_away(longint v, int s);
    longint h;
    h = longint'(1) << (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -(((-v) + h) >>> s);
  endfunction

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // rotation cordic: angle Q3.15 -> cos, sin Q1.14
  task automatic rotate_angle(input int a, output int c, output int s);
    bit neg;
    longint x, y, z, xs, ys;
    neg = 0;
    x = prac_pkg::GAIN_Q30;
    y = 0;
    if (a > prac_pkg::HALF_PI_Q15) begin
      a = a - prac_pkg::PI_Q15; neg = 1;
    end else if (a < -prac_pkg::HALF_PI_Q15) begin
      a = a + prac_pkg::PI_Q15; neg = 1;
    end
    z = longint'(a) * 32768;
    for (int i = 0; i < N_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_Q30[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN_Q30[i];
      end
    end
    x = round_away(x, 16);
    y = round_away(y, 16);
    if (neg) begin
      x = -x; y = -y;
    end
    c = int'(sat(x, prac_pkg::ONE_Q14));
    s = int'(sat(y, prac_pkg::ONE_Q14));
  endtask

  // vectoring cordic: atan2 in Q3.15 and gained magnitude
  task automatic vector_angle(input longint x, input longint y, output int ang,
                              output longint mag);
    longint z, off, xs, ys;
    z = 0;
    off = 0;
    if (x == 0 && y == 0) begin
      mag = 0; ang = 0;
    end else begin
      if (x < 0) begin
        off = (y >= 0) ? longint'(prac_pkg::PI_Q30) : -longint'(prac_pkg::PI_Q30);
        x = -x; y = -y;
      end
      for (int i = 0; i < N_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + ATAN_Q30[i];
        end else begin
          x = x - ys; y = y + xs; z = z - ATAN_Q30[i];
        end
      end
      mag = x;
      ang = int'(sat(round_away(z + off, 15), prac_pkg::PI_Q15));
    end
  endtask

  // advance the rotation state by one item
  task automatic predict_rotation(input prac_pkg::act_t act,
                                  input logic signed [17:0] ang_raw,
                                  input logic signed [15:0] vx, input logic signed [15:0] vy,
                                  output rot_t r);
    int a, oc, os, va;
    longint m, mag, nc, ns;
    a = ang_raw;
    if (a > prac_pkg::PI_Q15) a = a - prac_pkg::TWO_PI_Q15;
    else if (a < -prac_pkg::PI_Q15) a = a + prac_pkg::TWO_PI_Q15;
    case (act)
      prac_pkg::ACT_SET: begin
        pr_angle = a;
        rotate_angle(a, pr_cos, pr_sin);
      end
      prac_pkg::ACT_VEC: begin
        vector_angle(longint'(vx) * 16384, longint'(vy) * 16384, va, m);
        mag = round_away(m * prac_pkg::GAIN_Q30, 44);
        if (mag <= pr_floor) begin
          pr_angle = 0; pr_cos = prac_pkg::ONE_Q14; pr_sin = 0;
        end else begin
          pr_angle = va;
          rotate_angle(va, pr_cos, pr_sin);
        end
      end
      default: begin
        rotate_angle(a, oc, os);
        if (act == prac_pkg::ACT_SUB) os = -os;
        nc = round_away(longint'(pr_cos) * oc - longint'(pr_sin) * os, 14);
        ns = round_away(longint'(pr_cos) * os + longint'(pr_sin) * oc, 14);
        pr_cos = int'(sat(nc, prac_pkg::ONE_Q14));
        pr_sin = int'(sat(ns, prac_pkg::ONE_Q14));
        vector_angle(longint'(pr_cos) * 16384, longint'(pr_sin) * 16384, pr_angle, m);
      end
    endcase
    r.angle = 18'(pr_angle);
    r.cosv = 16'(pr_cos);
    r.sinv = 16'(pr_sin);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cyc);
    err_cnt++;
  endtask

  // wait until every pending result has come, then let the block settle
  task automatic drain_results();
    in_valid = 0;
    while (pending_rot.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_floor(input int v);
    drain_results();
    cfg_we = 1;
    cfg_data = v[15:0];
    @(negedge clk);
    cfg_we = 0;
    pr_floor = v;
  endtask

  // drive one item at a falling edge and hold until accepted
  task automatic send_item(input prac_pkg::act_t act, input logic signed [17:0] ang,
                           input logic signed [15:0] vx, input logic signed [15:0] vy,
                           input bit typed, input rot_t typed_rot);
    rot_t r;
    bit taken;
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    action = act;
    angle_in = ang;
    vec_x = vx;
    vec_y = vy;
    in_valid = 1;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = in_ready;
      if (taken) begin
        predict_rotation(act, ang, vx, vy, r);
        pending_rot.push_back(typed ? typed_rot : r);
      end
      @(negedge clk);
    end
  endtask

  task automatic add_row(input prac_pkg::act_t act, input int ang, input int vx,
                         input int vy, input int fl, input bit typed, input int ea,
                         input int ec, input int es);
    row_t t;
    t.act = act; t.ang = 18'(ang); t.vx = 16'(vx); t.vy = 16'(vy); t.floor_val = fl;
    t.typed = typed;
    t.want.angle = 18'(ea); t.want.cosv = 16'(ec); t.want.sinv = 16'(es);
    dir_tab.push_back(t);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
  end

  // compare each accepted result with the oldest pending one
  always @(posedge clk) begin
    rot_t w;
    cyc <= cyc + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_rot.size() == 0) begin
        report("unexpected result angle", angle_out, 0);
      end else begin
        w = pending_rot.pop_front();
        if (angle_out !== w.angle) report("angle_out", angle_out, w.angle);
        if (cos_out !== w.cosv) report("cos_out", cos_out, w.cosv);
        if (sin_out !== w.sinv) report("sin_out", sin_out, w.sinv);
      end
    end
  end

  // runaway guard
  always @(posedge clk) begin
    if (cyc > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rot_t none;
    prac_pkg::act_t act;
    logic signed [17:0] ang;
    logic signed [15:0] vx, vy;
    int floors [3];
    none.angle = 0; none.cosv = 0; none.sinv = 0;
    pr_angle = 0; pr_cos = prac_pkg::ONE_Q14; pr_sin = 0; pr_floor = 0;

    repeat (5) @(negedge clk);
    rst = 0;

    // directed: extremes, all actions, wrap, zero and small vectors
    add_row(prac_pkg::ACT_VEC, 0, 0, 0, 0, 1, 0, 16384, 0);
    add_row(prac_pkg::ACT_SET, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_SET, 102944, -1, -1, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_SET, -102944, 0, 0, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_SET, 131071, 32767, -32768, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_SET, -131072, 0, 0, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_SET, 51472, 0, 0, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_ADD, 102944, 0, 0, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_SUB, -51473, 0, 0, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_ADD, -131072, 32767, 32767, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_SUB, 131071, -32768, -32768, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_VEC, -131072, 32767, 32767, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_VEC, 131071, -32768, -32768, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_VEC, 0, -32768, 0, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_VEC, 0, 0, -32768, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_VEC, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_VEC, 0, -1, 0, 0, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_VEC, 0, 100, -200, 65535, 1, 0, 16384, 0);
    add_row(prac_pkg::ACT_VEC, 0, 32767, 32767, 65535, 1, 0, 16384, 0);
    add_row(prac_pkg::ACT_VEC, 0, 2, 1, 3, 1, 0, 16384, 0);
    add_row(prac_pkg::ACT_VEC, 0, 3, 0, 3, 1, 0, 16384, 0);
    add_row(prac_pkg::ACT_VEC, 0, 4, 0, 3, 0, 0, 0, 0);
    add_row(prac_pkg::ACT_SUB, 0, 0, 0, 3, 0, 0, 0, 0);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].floor_val != pr_floor) write_floor(dir_tab[k].floor_val);
      send_item(dir_tab[k].act, dir_tab[k].ang, dir_tab[k].vx, dir_tab[k].vy,
                dir_tab[k].typed, dir_tab[k].want);
    end

    // random phases with different idle patterns and floors
    floors[0] = 0;
    floors[1] = $urandom_range(1, 3000);
    floors[2] = 65535;
    for (int ph = 0; ph < 3; ph++) begin
      write_floor(floors[ph]);
      send_idle = (ph == 0) ? 17 : (ph == 1) ? 80 : 0;
      recv_idle = (ph == 0) ? 80 : (ph == 1) ? 17 : 0;
      for (int n = 0; n < RAND_ITEMS / 3; n++) begin
        act = prac_pkg::act_t'($urandom_range(3));
        if ($urandom_range(3) == 0) ang = 18'($urandom_range(205888) - 102944);
        else ang = 18'($urandom);
        if ($urandom_range(2) == 0) begin
          vx = 16'($signed($urandom_range(128)) - 64);
          vy = 16'($signed($urandom_range(128)) - 64);
        end else begin
          vx = 16'($urandom);
          vy = 16'($urandom);
        end
        send_item(act, ang, vx, vy, 0, none);
        // hold the sender off until the block is empty
        if (n == 100) drain_results();
      end
    end

    drain_results();
    if (err_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/prac_pkg.sv
src/prac_dp.sv
src/prac_ctrl.sv
src/planar_rotation_accumulator.sv
tb/sv/tb_planar_rotation_accumulator.sv
